FILE: sv/http2_frame_header_decoder_unit_macros.svh
// Assertion macros for the HTTP/2 frame header decoder.
// Used by the modules that check their own logic; expects clk and arst_n in scope.
`ifndef HTTP2_FRAME_HEADER_DECODER_UNIT_MACROS_SVH
`define HTTP2_FRAME_HEADER_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define H2FHD_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define H2FHD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/h2fhd_pkg.sv
// Shared types and constants for the HTTP/2 frame header decoder.
// No dependencies; imported by every module of the block.
package h2fhd_pkg;

	localparam int COUNT_W     = 25;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [COUNT_W-1:0] HDR_BYTES = COUNT_W'(9);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Header byte positions within a buffer
	localparam logic [3:0] HB_LEN_HI  = 4'd0;
	localparam logic [3:0] HB_LEN_MID = 4'd1;
	localparam logic [3:0] HB_LEN_LO  = 4'd2;
	localparam logic [3:0] HB_TYPE    = 4'd3;
	localparam logic [3:0] HB_FLAGS   = 4'd4;
	localparam logic [3:0] HB_SID_3   = 4'd5;
	localparam logic [3:0] HB_SID_2   = 4'd6;
	localparam logic [3:0] HB_SID_1   = 4'd7;
	localparam logic [3:0] HB_SID_0   = 4'd8;

	localparam logic [7:0]  PING_TYPE = 8'd6;
	localparam logic [23:0] PING_LEN  = 24'd8;

	// Result kinds and status codes
	localparam logic       KIND_PAYLOAD = 1'b0;
	localparam logic       KIND_STATUS  = 1'b1;
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_PROTO = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [23:0] frame_length;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [30:0] stream_ident;
		logic [1:0]  status;
		logic        end_of_result;
	} out_item_t;

	// Classified byte, as queued between front and back
	typedef struct packed {
		logic        pay_v;
		logic        stat_v;
		logic [7:0]  pbyte;
		logic [1:0]  status;
		logic [23:0] length;
		logic [7:0]  ftype;
		logic [7:0]  flags;
		logic [30:0] stream;
	} op_t;

endpackage

FILE: sv/http2_frame_header_decoder_unit.sv
// HTTP/2 frame header decoder. Takes one buffer byte per cycle on the data
// channel and gathers the nine-byte frame header; payload bytes inside the
// frame length come out as payload words carrying the header fields, and the
// byte flagged last yields a status word (ok, short, protocol error). One
// byte is accepted every cycle that the queue is not full; a byte that both
// falls in the payload and ends the buffer gives two words, which the back
// end sends one after the other while the front end keeps taking bytes into a
// QDEPTH-entry queue. Each word passes through that queue and the output
// register on its way to the result port, and the block stalls only when
// that queue is full. Depends on h2fhd_pkg, h2fhd_front, h2fhd_fifo and h2fhd_back.
module http2_frame_header_decoder_unit #(
	parameter int QDEPTH = h2fhd_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_stall,
	input  h2fhd_pkg::in_item_t  data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output h2fhd_pkg::out_item_t result
);
	import h2fhd_pkg::*;

	op_t  push_op, head;
	logic push, pop, q_empty, q_full;

	h2fhd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data       (data),
		.op_push    (push),
		.op         (push_op),
		.q_full     (q_full)
	);

	h2fhd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_op  (push_op),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	h2fhd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: sv/h2fhd_front.sv
// Front end: accepts buffer bytes, gathers the header and classifies each byte.
// Depends on h2fhd_pkg; pushes op_t entries into h2fhd_fifo.
module h2fhd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_stall,
	input  h2fhd_pkg::in_item_t data,
	output logic               op_push,
	output h2fhd_pkg::op_t     op,
	input  logic               q_full
);
	import h2fhd_pkg::*;

	logic [COUNT_W-1:0] count_q, count_n;
	logic [23:0]        len_q, len_n;
	logic [7:0]         type_q, type_n;
	logic [7:0]         flags_q, flags_n;
	logic [30:0]        stream_q, stream_n;
	logic               accept, is_pay, is_hdr, ping_bad;
	logic [1:0]         status;

	assign data_stall = q_full;
	assign accept     = data_valid && !q_full;
	assign is_hdr     = count_q < HDR_BYTES;

	// Header capture: fold this byte into the gathered fields
	always_comb begin
		len_n    = len_q;
		type_n   = type_q;
		flags_n  = flags_q;
		stream_n = stream_q;
		if (is_hdr) begin
			unique case (count_q[3:0])
				HB_LEN_HI:  len_n[23:16]    = data.data_byte;
				HB_LEN_MID: len_n[15:8]     = data.data_byte;
				HB_LEN_LO:  len_n[7:0]      = data.data_byte;
				HB_TYPE:    type_n          = data.data_byte;
				HB_FLAGS:   flags_n         = data.data_byte;
				HB_SID_3:   stream_n[30:24] = data.data_byte[6:0];
				HB_SID_2:   stream_n[23:16] = data.data_byte;
				HB_SID_1:   stream_n[15:8]  = data.data_byte;
				HB_SID_0:   stream_n[7:0]   = data.data_byte;
				default:    stream_n        = stream_q;
			endcase
		end
	end

	// Byte within the payload window
	assign is_pay  = !is_hdr && ((count_q - HDR_BYTES) < {1'b0, len_q});
	assign count_n = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	// End-of-buffer status, truncation before the PING check
	assign ping_bad = (type_n == PING_TYPE) && ((len_n != PING_LEN) || (stream_n != '0));
	always_comb begin
		if (count_n < HDR_BYTES) begin
			status = STATUS_SHORT;
		end else if ((count_n - HDR_BYTES) < {1'b0, len_n}) begin
			status = STATUS_PROTO;
		end else if (ping_bad) begin
			status = STATUS_PROTO;
		end else begin
			status = STATUS_OK;
		end
	end

	// Queue entry; a short buffer reports empty header fields
	always_comb begin
		op.pay_v  = is_pay;
		op.stat_v = data.last_byte;
		op.pbyte  = data.data_byte;
		op.status = status;
		if (data.last_byte && (status == STATUS_SHORT)) begin
			op.length = '0;
			op.ftype  = '0;
			op.flags  = '0;
			op.stream = '0;
		end else begin
			op.length = len_n;
			op.ftype  = type_n;
			op.flags  = flags_n;
			op.stream = stream_n;
		end
	end

	assign op_push = accept && (is_pay || data.last_byte);

	// Per-buffer state, back to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			len_q    <= '0;
			type_q   <= '0;
			flags_q  <= '0;
			stream_q <= '0;
		end else if (accept) begin
			if (data.last_byte) begin
				count_q  <= '0;
				len_q    <= '0;
				type_q   <= '0;
				flags_q  <= '0;
				stream_q <= '0;
			end else begin
				count_q  <= count_n;
				len_q    <= len_n;
				type_q   <= type_n;
				flags_q  <= flags_n;
				stream_q <= stream_n;
			end
		end
	end

endmodule

FILE: sv/h2fhd_fifo.sv
// Short queue of classified bytes between front and back end.
// Depends on h2fhd_pkg for op_t; storage held in flops.
module h2fhd_fifo #(
	parameter int DEPTH = h2fhd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  h2fhd_pkg::op_t wr_op,
	input  logic           pop,
	output h2fhd_pkg::op_t head,
	output logic           empty,
	output logic           full
);
	import h2fhd_pkg::*;

	`include "http2_frame_header_decoder_unit_macros.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = entry_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wr_op;
		end
	end

	`H2FHD_ASSERT_SAME(a_no_overflow, push, !full, "queue written while full")
	`H2FHD_ASSERT_SAME(a_no_underflow, pop, !empty, "queue read while empty")
	`H2FHD_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "count did not rise")

endmodule

FILE: sv/h2fhd_back.sv
// Back end: turns queued entries into result words behind an output register.
// Depends on h2fhd_pkg; reads the head of h2fhd_fifo.
module h2fhd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  h2fhd_pkg::op_t        head,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output h2fhd_pkg::out_item_t  result
);
	import h2fhd_pkg::*;

	`include "http2_frame_header_decoder_unit_macros.svh"

	out_item_t res_q, res_n;
	logic      res_valid_q, pay_sent_q;
	logic      load, finish;

	// Load when an entry waits and the output register is free or being emptied this cycle
	assign load = !q_empty && (!res_valid_q || !result_stall);

	// Payload word first, then the status record of the same entry
	always_comb begin
		res_n.frame_length = head.length;
		res_n.frame_type   = head.ftype;
		res_n.frame_flags  = head.flags;
		res_n.stream_ident = head.stream;
		if (head.pay_v && !pay_sent_q) begin
			res_n.result_kind   = KIND_PAYLOAD;
			res_n.payload_byte  = head.pbyte;
			res_n.status        = STATUS_OK;
			res_n.end_of_result = 1'b0;
			finish              = !head.stat_v;
		end else begin
			res_n.result_kind   = KIND_STATUS;
			res_n.payload_byte  = '0;
			res_n.status        = head.status;
			res_n.end_of_result = 1'b1;
			finish              = 1'b1;
		end
	end

	assign pop          = load && finish;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Control: output valid and the half-done marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pay_sent_q  <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				pay_sent_q  <= !finish;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_n;
		end
	end

	`H2FHD_ASSERT_SAME(a_half_done_head, pay_sent_q, !q_empty && head.stat_v, "split entry lost its status")

endmodule

FILE: verif/h2fhd_frame_checker.sv
// Frame checker for the HTTP/2 frame header decoder: predicts the words each
// accepted byte should produce and compares them with the result channel.
// Depends on h2fhd_pkg only.
module h2fhd_frame_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	input  logic                 data_stall,
	input  h2fhd_pkg::in_item_t  data,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  h2fhd_pkg::out_item_t result,
	output int                   fail_count,
	output int                   outstanding,
	output int                   payload_words,
	output int                   status_words
);
	timeunit 1ns;
	timeprecision 1ps;

	import h2fhd_pkg::*;

	// Predicted decoder state
	logic [COUNT_W-1:0] seen_cnt;
	logic [23:0]        hdr_len;
	logic [7:0]         hdr_type;
	logic [7:0]         hdr_flags;
	logic [30:0]        hdr_sid;

	out_item_t expected_words[$];
	int        errs = 0;
	int        n_payload = 0;
	int        n_status = 0;

	initial begin
		fail_count = 0;
		outstanding = 0;
		payload_words = 0;
		status_words = 0;
	end

	task automatic clear_frame();
		seen_cnt = '0;
		hdr_len = '0;
		hdr_type = '0;
		hdr_flags = '0;
		hdr_sid = '0;
	endtask

	function automatic out_item_t with_header(input out_item_t w);
		out_item_t r;
		r = w;
		r.frame_length = hdr_len;
		r.frame_type = hdr_type;
		r.frame_flags = hdr_flags;
		r.stream_ident = hdr_sid;
		return r;
	endfunction

	// Works out the words one byte gives and queues them in order
	task automatic decode_byte(input in_item_t it);
		logic [COUNT_W-1:0] pos;
		out_item_t w;
		pos = seen_cnt;
		w = '0;
		if (pos < HDR_BYTES) begin
			case (pos[3:0])
				HB_LEN_HI:  hdr_len[23:16] = it.data_byte;
				HB_LEN_MID: hdr_len[15:8] = it.data_byte;
				HB_LEN_LO:  hdr_len[7:0] = it.data_byte;
				HB_TYPE:    hdr_type = it.data_byte;
				HB_FLAGS:   hdr_flags = it.data_byte;
				HB_SID_3:   hdr_sid[30:24] = it.data_byte[6:0];  // reserved bit dropped
				HB_SID_2:   hdr_sid[23:16] = it.data_byte;
				HB_SID_1:   hdr_sid[15:8] = it.data_byte;
				HB_SID_0:   hdr_sid[7:0] = it.data_byte;
				default: ;
			endcase
		end else if (pos - HDR_BYTES < COUNT_W'(hdr_len)) begin
			w.result_kind = KIND_PAYLOAD;
			w.payload_byte = it.data_byte;
			w.status = STATUS_OK;
			w.end_of_result = 1'b0;
			expected_words = {expected_words, with_header(w)};
		end
		// Count saturates so very long buffers keep being ignored
		if (seen_cnt != COUNT_MAX)
			seen_cnt = seen_cnt + 1'b1;
		if (it.last_byte) begin
			w = '0;
			w.result_kind = KIND_STATUS;
			w.end_of_result = 1'b1;
			if (seen_cnt < HDR_BYTES) begin
				w.status = STATUS_SHORT;
			end else begin
				w = with_header(w);
				if (seen_cnt - HDR_BYTES < COUNT_W'(hdr_len))
					w.status = STATUS_PROTO;
				else if (hdr_type == PING_TYPE && (hdr_len != PING_LEN || hdr_sid != '0))
					w.status = STATUS_PROTO;
				else
					w.status = STATUS_OK;
			end
			expected_words = {expected_words, w};
			clear_frame();
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
			errs++;
		end
	endtask

	// Compares one result word with the oldest prediction
	task automatic compare_word(input out_item_t got);
		out_item_t want;
		if (expected_words.size() == 0) begin
			$error("result word arrived with nothing expected");
			errs++;
		end else begin
			want = expected_words.pop_front();
			check_field("result_kind", want.result_kind, got.result_kind);
			check_field("payload_byte", want.payload_byte, got.payload_byte);
			check_field("frame_length", want.frame_length, got.frame_length);
			check_field("frame_type", want.frame_type, got.frame_type);
			check_field("frame_flags", want.frame_flags, got.frame_flags);
			check_field("stream_ident", want.stream_ident, got.stream_ident);
			check_field("status", want.status, got.status);
			check_field("end_of_result", want.end_of_result, got.end_of_result);
			if (want.result_kind == KIND_STATUS)
				n_status++;
			else
				n_payload++;
		end
	endtask

	// Watch both channels; outputs settle after the edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			expected_words.delete();
		end else begin
			if (result_valid && !result_stall)
				compare_word(result);
			if (data_valid && !data_stall)
				decode_byte(data);
		end
		outstanding <= expected_words.size();
		fail_count <= errs;
		payload_words <= n_payload;
		status_words <= n_status;
	end

endmodule

FILE: verif/tb_http2_frame_header_decoder_unit.sv
// Testbench top for the HTTP/2 frame header decoder: drives buffers of bytes,
// stalls the result side at random and gives the verdict.
// Depends on h2fhd_pkg, h2fhd_frame_checker and the decoder RTL.
module tb_http2_frame_header_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import h2fhd_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_BYTES = 750;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      data_valid;
	logic      data_stall;
	in_item_t  data;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	int fail_count;
	int outstanding;
	int payload_words;
	int status_words;

	int unsigned cycles = 0;
	int          bytes_sent = 0;
	int          buffers_sent = 0;
	logic [7:0]  frame_bytes[$];

	always #6 clk = ~clk;

	http2_frame_header_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data         (data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	h2fhd_frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data          (data),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.payload_words (payload_words),
		.status_words  (status_words)
	);

	// Cycle count and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver back-pressure, with a calm window of no stalls
	always @(posedge clk) begin
		if (cycles >= 300 && cycles < 500)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(0, 99) < 17);
	end

	// Appends one byte to the buffer being built
	task automatic add_byte(input logic [7:0] b);
		frame_bytes = {frame_bytes, b};
	endtask

	// One byte over the data channel, with random gaps before it
	task automatic send_byte(input in_item_t it);
		while (!(bytes_sent >= 350 && bytes_sent < 500) && $urandom_range(0, 99) < 17) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data <= it;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Sends the gathered buffer, flagging its final byte
	task automatic send_buffer();
		in_item_t it;
		foreach (frame_bytes[i]) begin
			it.data_byte = frame_bytes[i];
			it.last_byte = (i == frame_bytes.size() - 1);
			send_byte(it);
		end
		frame_bytes.delete();
		buffers_sent++;
	endtask

	task automatic put_header(input logic [23:0] len, input logic [7:0] ftype,
	                          input logic [7:0] flags, input logic [31:0] sid);
		add_byte(len[23:16]);
		add_byte(len[15:8]);
		add_byte(len[7:0]);
		add_byte(ftype);
		add_byte(flags);
		add_byte(sid[31:24]);
		add_byte(sid[23:16]);
		add_byte(sid[15:8]);
		add_byte(sid[7:0]);
	endtask

	// Mostly well-formed frames; some short buffers and raw noise
	task automatic random_buffer();
		int          pick;
		int          keep;
		logic [23:0] len;
		logic [7:0]  ftype;
		logic [31:0] sid;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom_range(0, 255)));
		end else if (pick < 20) begin
			repeat ($urandom_range(9, 24))
				add_byte(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				ftype = PING_TYPE;
				len = ($urandom_range(0, 2) != 0) ? PING_LEN : 24'($urandom_range(0, 12));
				if ($urandom_range(0, 1) != 0)
					sid = {1'($urandom_range(0, 1)), 31'd0};
				else
					sid = $urandom();
			end else begin
				ftype = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) == 0)
					len = 24'($urandom_range(13, 48));
				else
					len = 24'($urandom_range(0, 12));
				sid = $urandom();
			end
			put_header(len, ftype, 8'($urandom_range(0, 255)), sid);
			keep = len;
			// Occasionally cut the payload short
			if (len != 0 && $urandom_range(0, 7) == 0)
				keep = len - $urandom_range(1, len);
			repeat (keep)
				add_byte(8'($urandom_range(0, 255)));
			if (keep == len && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					add_byte(8'($urandom_range(0, 255)));
		end
		send_buffer();
	endtask

	initial begin
		arst_n <= 1'b0;
		data_valid <= 1'b0;
		data <= '0;
		result_stall <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Single byte: too short for a header
		add_byte(8'h00);
		send_buffer();
		// Two bytes, all ones
		add_byte(8'hFF);
		add_byte(8'hFF);
		send_buffer();
		// Empty payload, all-ones type, flags and stream, reserved bit set, one trailing byte
		put_header(24'h000000, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		add_byte(8'h00);
		send_buffer();
		// PING with wrong length and only the reserved stream bit, payload cut short
		put_header(24'd3, PING_TYPE, 8'h00, 32'h8000_0000);
		add_byte(8'hFF);
		send_buffer();

		while (bytes_sent < RANDOM_BYTES + 23)
			random_buffer();
		data_valid <= 1'b0;

		// Drain, then wait on for stray words
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("run covered %0d buffers, %0d bytes in %0d cycles", buffers_sent,
		         bytes_sent, cycles);
		$display("checked %0d payload words and %0d status words", payload_words,
		         status_words);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/h2fhd_pkg.sv
sv/h2fhd_front.sv
sv/h2fhd_fifo.sv
sv/h2fhd_back.sv
sv/http2_frame_header_decoder_unit.sv
verif/h2fhd_frame_checker.sv
verif/tb_http2_frame_header_decoder_unit.sv
